>>> src/obpc_pkg.sv
// ----------------------------------------------------------------------------
// obpc_pkg
// Shared types and constants for the oriented box point crop block.
// ----------------------------------------------------------------------------
package obpc_pkg;

  localparam int unsigned RegW   = 48;
  localparam int unsigned LaneW  = 16;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DiffW  = LaneW + 1;
  localparam int unsigned ProdW  = LaneW + DiffW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned DimSh  = 13;

  localparam logic [IdxW-1:0] REG_ROT_X  = 3'd0;
  localparam logic [IdxW-1:0] REG_ROT_Y  = 3'd1;
  localparam logic [IdxW-1:0] REG_ROT_Z  = 3'd2;
  localparam logic [IdxW-1:0] REG_CENTER = 3'd3;
  localparam logic [IdxW-1:0] REG_DIMS   = 3'd4;

  localparam logic [RegW-1:0] ROT_X_RST = 48'h0000_0000_4000;
  localparam logic [RegW-1:0] ROT_Y_RST = 48'h0000_4000_0000;
  localparam logic [RegW-1:0] ROT_Z_RST = 48'h4000_0000_0000;

  typedef struct packed {
    logic [RegW-1:0] rot_x;
    logic [RegW-1:0] rot_y;
    logic [RegW-1:0] rot_z;
    logic [RegW-1:0] center;
    logic [RegW-1:0] dims;
  } cfg_t;

  typedef struct packed {
    logic [LaneW-1:0] x;
    logic [LaneW-1:0] y;
    logic [LaneW-1:0] z;
    logic             last;
  } point_t;

endpackage

>>> src/obpc_cfg.sv
// ----------------------------------------------------------------------------
// obpc_cfg
// Configuration register file: rotation columns, center and dimensions.
// ----------------------------------------------------------------------------
module obpc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [obpc_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [obpc_pkg::RegW-1:0]     cfg_data_i,
  output obpc_pkg::cfg_t                cfg_o
);

  obpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        obpc_pkg::REG_ROT_X:  cfg_d.rot_x  = cfg_data_i;
        obpc_pkg::REG_ROT_Y:  cfg_d.rot_y  = cfg_data_i;
        obpc_pkg::REG_ROT_Z:  cfg_d.rot_z  = cfg_data_i;
        obpc_pkg::REG_CENTER: cfg_d.center = cfg_data_i;
        obpc_pkg::REG_DIMS:   cfg_d.dims   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_x  <= obpc_pkg::ROT_X_RST;
      cfg_q.rot_y  <= obpc_pkg::ROT_Y_RST;
      cfg_q.rot_z  <= obpc_pkg::ROT_Z_RST;
      cfg_q.center <= '0;
      cfg_q.dims   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/obpc_proj.sv
// ----------------------------------------------------------------------------
// obpc_proj
// Three-stage projection pipeline: center subtract, lane multiplies, axis sums.
// ----------------------------------------------------------------------------
module obpc_proj (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  obpc_pkg::cfg_t                      cfg_i,
  input  logic                                valid_i,
  input  obpc_pkg::point_t                    point_i,
  output logic                                valid_o,
  output obpc_pkg::point_t                    point_o,
  output logic signed [obpc_pkg::SumW-1:0]    sum_o [3]
);

  localparam int unsigned LW = obpc_pkg::LaneW;
  localparam int unsigned DW = obpc_pkg::DiffW;
  localparam int unsigned PW = obpc_pkg::ProdW;
  localparam int unsigned SW = obpc_pkg::SumW;

  logic v1_q, v2_q, v3_q;
  obpc_pkg::point_t pt1_q, pt2_q, pt3_q;

  logic signed [DW-1:0] diff_d [3];
  logic signed [DW-1:0] diff_q [3];
  logic signed [PW-1:0] prod_d [3][3];
  logic signed [PW-1:0] prod_q [3][3];
  logic signed [SW-1:0] sum_d  [3];
  logic signed [SW-1:0] sum_q  [3];
  logic [obpc_pkg::RegW-1:0] col [3];
  logic [LW-1:0] pin [3];

  assign col[0] = cfg_i.rot_x;
  assign col[1] = cfg_i.rot_y;
  assign col[2] = cfg_i.rot_z;
  assign pin[0] = point_i.x;
  assign pin[1] = point_i.y;
  assign pin[2] = point_i.z;

  // stage 1: point minus center
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_d[k] = DW'($signed(pin[k])) - DW'($signed(cfg_i.center[k*LW +: LW]));
    end
  end

  // stage 2: column lane times difference
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[i][k] = PW'($signed(col[i][k*LW +: LW])) * PW'(diff_q[k]);
      end
    end
  end

  // stage 3: sum per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = SW'(prod_q[i][0]) + SW'(prod_q[i][1]) + SW'(prod_q[i][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pt1_q  <= point_i;
    pt2_q  <= pt1_q;
    pt3_q  <= pt2_q;
    diff_q <= diff_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign valid_o = v3_q;
  assign point_o = pt3_q;
  assign sum_o   = sum_q;

  a_v1_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $past(valid_i)) else $error("stage 1 valid without request");
  a_v2_from_v1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q)) else $error("stage 2 valid without stage 1");
  a_v3_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (pt3_q.last == $past(pt2_q.last))) else $error("last mark lost");

endmodule

>>> src/obpc_cmp.sv
// ----------------------------------------------------------------------------
// obpc_cmp
// Final stage: magnitude of each local coordinate against half the extent.
// ----------------------------------------------------------------------------
module obpc_cmp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [obpc_pkg::RegW-1:0]           dims_i,
  input  logic                                valid_i,
  input  obpc_pkg::point_t                    point_i,
  input  logic signed [obpc_pkg::SumW-1:0]    sum_i [3],
  output logic                                valid_o,
  output logic                                keep_o,
  output obpc_pkg::point_t                    point_o
);

  localparam int unsigned LW = obpc_pkg::LaneW;
  localparam int unsigned SW = obpc_pkg::SumW;

  logic [SW-1:0] mag [3];
  logic [SW-1:0] lim [3];
  logic [2:0]    ok;
  logic          valid_q, keep_q;
  obpc_pkg::point_t point_q;

  // 2*|s| <= dim*2^14 is |s| <= dim*2^13
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = sum_i[i][SW-1] ? SW'(-sum_i[i]) : SW'(sum_i[i]);
      lim[i] = SW'({dims_i[i*LW +: LW], {obpc_pkg::DimSh{1'b0}}});
      ok[i]  = (mag[i] <= lim[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      keep_q  <= 1'b0;
    end else begin
      valid_q <= valid_i;
      keep_q  <= valid_i & (&ok);
    end
  end

  always_ff @(posedge clk_i) begin
    point_q <= point_i;
  end

  assign valid_o = valid_q;
  assign keep_o  = keep_q;
  assign point_o = point_q;

  a_keep_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_q |-> valid_q) else $error("keep without result");

endmodule

>>> src/oriented_box_point_crop_core.sv
// ----------------------------------------------------------------------------
// oriented_box_point_crop_core
// Oriented bounding box test on a stream of 3D points.
//
// A request is taken on every rising edge with start_i high and busy_o low;
// busy_o stays low, so one point can enter in every cycle. Each point is
// centered, projected onto the three rotation columns and its local
// coordinates are checked against half the box extents.
// Every request produces exactly one result after the four register stages:
// done_o is high for one cycle with the point passed through, keep_o and out_last_o.
// Throughput is one point per cycle, set by the four register stages
// (subtract, multiply, sum, compare) all advancing together.
// The receiver cannot stall; results are presented once and not held.
// Configuration uses cfg_we_i, cfg_idx_i and cfg_data_i; the user must write it only
// while no point is in flight (not enforced by the block); unknown indexes are ignored.
// Reset clears the pipeline valids and loads identity rotation columns,
// zero center and zero dimensions.
// ----------------------------------------------------------------------------
module oriented_box_point_crop_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [obpc_pkg::IdxW-1:0]       cfg_idx_i,
  input  logic [obpc_pkg::RegW-1:0]       cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [15:0]              point_x_i,
  input  logic signed [15:0]              point_y_i,
  input  logic signed [15:0]              point_z_i,
  input  logic                            last_point_i,
  output logic                            done_o,
  output logic signed [15:0]              out_x_o,
  output logic signed [15:0]              out_y_o,
  output logic signed [15:0]              out_z_o,
  output logic                            keep_o,
  output logic                            out_last_o
);

  obpc_pkg::cfg_t   cfg;
  obpc_pkg::point_t pt_in, pt_proj, pt_out;
  logic             accept, proj_valid;
  logic signed [obpc_pkg::SumW-1:0] sums [3];

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign pt_in.x    = point_x_i;
  assign pt_in.y    = point_y_i;
  assign pt_in.z    = point_z_i;
  assign pt_in.last = last_point_i;

  obpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  obpc_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (accept),
    .point_i (pt_in),
    .valid_o (proj_valid),
    .point_o (pt_proj),
    .sum_o   (sums)
  );

  obpc_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dims_i  (cfg.dims),
    .valid_i (proj_valid),
    .point_i (pt_proj),
    .sum_i   (sums),
    .valid_o (done_o),
    .keep_o  (keep_o),
    .point_o (pt_out)
  );

  assign out_x_o    = pt_out.x;
  assign out_y_o    = pt_out.y;
  assign out_z_o    = pt_out.z;
  assign out_last_o = pt_out.last;

  a_done_from_proj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(proj_valid)) else $error("result without projection");
  a_keep_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_o |-> done_o) else $error("keep outside result cycle");

endmodule

>>> tb/sv/oriented_box_point_crop_core_tb.sv
// ----------------------------------------------------------------------------
// oriented_box_point_crop_core_tb
// Self-checking testbench for the oriented box point crop core.
//
// A short directed table covers reset defaults, extreme coordinates, zero and
// full box extents, extreme and degenerate rotation columns and writes to
// unused register indexes. Random boxes and points follow in three phases of
// sender idling. Results are checked against the table or a box predictor.
// ----------------------------------------------------------------------------
module oriented_box_point_crop_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RegW  = obpc_pkg::RegW;
  localparam int unsigned LaneW = obpc_pkg::LaneW;
  localparam int unsigned IdxW  = obpc_pkg::IdxW;

  localparam int unsigned ClkPeriod  = 4;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;

  localparam logic [IdxW-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [IdxW-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum logic {ROW_REG, ROW_POINT} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [IdxW-1:0]  idx;
    logic [RegW-1:0]  data;
    logic [LaneW-1:0] x;
    logic [LaneW-1:0] y;
    logic [LaneW-1:0] z;
    logic             last;
    bit               has_keep;
    logic             keep;
  } stim_row_t;

  typedef struct {
    logic [LaneW-1:0] x;
    logic [LaneW-1:0] y;
    logic [LaneW-1:0] z;
    logic             keep;
    logic             last;
  } crop_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [IdxW-1:0]         cfg_idx_i;
  logic [RegW-1:0]         cfg_data_i;
  logic                    start_i;
  logic                    busy_o;
  logic signed [15:0]      point_x_i;
  logic signed [15:0]      point_y_i;
  logic signed [15:0]      point_z_i;
  logic                    last_point_i;
  logic                    done_o;
  logic signed [15:0]      out_x_o;
  logic signed [15:0]      out_y_o;
  logic signed [15:0]      out_z_o;
  logic                    keep_o;
  logic                    out_last_o;

  obpc_pkg::cfg_t  box_cfg;
  crop_result_t    pending_points[$];
  stim_row_t       directed_rows[$];
  int unsigned     cycle_count  = 0;
  int unsigned     points_sent  = 0;
  int unsigned     results_seen = 0;
  int unsigned     points_kept  = 0;
  int unsigned     box_loads    = 0;
  int unsigned     mismatches   = 0;
  int unsigned     idle_pct;

  oriented_box_point_crop_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .done_o       (done_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .keep_o       (keep_o),
    .out_last_o   (out_last_o)
  );

  always #(ClkPeriod / 2.0) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("oriented_box_point_crop_core verification failed");
      $finish;
    end
  end

  function automatic longint lane_signed(logic [RegW-1:0] r, int k);
    logic signed [LaneW-1:0] v;
    v = r[k*LaneW +: LaneW];
    return longint'(v);
  endfunction

  function automatic logic point_in_box(obpc_pkg::cfg_t c, logic [LaneW-1:0] px,
                                        logic [LaneW-1:0] py, logic [LaneW-1:0] pz);
    longint          d [3];
    longint          s;
    longint          lim;
    logic [RegW-1:0] cols [3];
    logic            in_box;
    cols[0] = c.rot_x;
    cols[1] = c.rot_y;
    cols[2] = c.rot_z;
    d[0] = lane_signed({32'b0, px}, 0) - lane_signed(c.center, 0);
    d[1] = lane_signed({32'b0, py}, 0) - lane_signed(c.center, 1);
    d[2] = lane_signed({32'b0, pz}, 0) - lane_signed(c.center, 2);
    in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      s = lane_signed(cols[a], 0) * d[0] + lane_signed(cols[a], 1) * d[1] +
          lane_signed(cols[a], 2) * d[2];
      if (s < 0) s = -s;
      lim = longint'(c.dims[a*LaneW +: LaneW]);
      lim = lim << 14;
      if (2 * s > lim) in_box = 1'b0;
    end
    return in_box;
  endfunction

  always @(posedge clk_i) begin
    crop_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (keep_o) points_kept++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result x=%h y=%h z=%h keep=%b last=%b", $realtime,
                   out_x_o, out_y_o, out_z_o, keep_o, out_last_o);
      end else begin
        want = pending_points.pop_front();
        if (out_x_o !== want.x || out_y_o !== want.y || out_z_o !== want.z ||
            keep_o !== want.keep || out_last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] exp x=%h y=%h z=%h k=%b l=%b got x=%h y=%h z=%h k=%b l=%b",
                     $realtime, want.x, want.y, want.z, want.keep, want.last,
                     out_x_o, out_y_o, out_z_o, keep_o, out_last_o);
        end
      end
    end
  end

  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      obpc_pkg::REG_ROT_X:  box_cfg.rot_x  = data;
      obpc_pkg::REG_ROT_Y:  box_cfg.rot_y  = data;
      obpc_pkg::REG_ROT_Z:  box_cfg.rot_z  = data;
      obpc_pkg::REG_CENTER: box_cfg.center = data;
      obpc_pkg::REG_DIMS:   box_cfg.dims   = data;
      default: ;
    endcase
  endtask

  task automatic send_point(logic [LaneW-1:0] x, logic [LaneW-1:0] y, logic [LaneW-1:0] z,
                            logic last, logic keep);
    crop_result_t want;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    point_z_i    <= z;
    last_point_i <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    want.x    = x;
    want.y    = y;
    want.z    = z;
    want.keep = keep;
    want.last = last;
    pending_points = {pending_points, want};
    points_sent++;
  endtask

  task automatic send_predicted(logic [LaneW-1:0] x, logic [LaneW-1:0] y,
                                logic [LaneW-1:0] z, logic last);
    send_point(x, y, z, last, point_in_box(box_cfg, x, y, z));
  endtask

  function automatic void add_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_REG, default: '0};
    r.idx  = idx;
    r.data = data;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_point(logic [LaneW-1:0] x, logic [LaneW-1:0] y,
                                    logic [LaneW-1:0] z, logic last, bit has_keep,
                                    logic keep);
    stim_row_t r;
    r = '{kind: ROW_POINT, default: '0};
    r.x        = x;
    r.y        = y;
    r.z        = z;
    r.last     = last;
    r.has_keep = has_keep;
    r.keep     = keep;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic logic [LaneW-1:0] rand_rot_lane(int mode, bit diag);
    int v;
    case (mode)
      0: v = diag ? 16384 : 0;
      1: v = $urandom_range(65535);
      2: v = diag ? ($urandom_range(1) ? 16384 : -16384) : 0;
      default: v = diag ? 16384 + $urandom_range(4000) - 2000 : $urandom_range(12000) - 6000;
    endcase
    return v[LaneW-1:0];
  endfunction

  task automatic load_random_box();
    logic [RegW-1:0] cols [3];
    logic [RegW-1:0] ctr;
    logic [RegW-1:0] dims;
    int              mode;
    int              perm;
    mode = $urandom_range(3);
    perm = $urandom_range(2);
    for (int a = 0; a < 3; a++)
      for (int k = 0; k < 3; k++)
        cols[a][k*LaneW +: LaneW] = rand_rot_lane(mode, ((a + perm) % 3) == k);
    for (int k = 0; k < 3; k++) begin
      ctr[k*LaneW +: LaneW]  = LaneW'($urandom_range(1) ? $urandom_range(65535)
                                                        : $urandom_range(4096) - 2048);
      case ($urandom_range(4))
        0:       dims[k*LaneW +: LaneW] = LaneW'($urandom_range(65535));
        1:       dims[k*LaneW +: LaneW] = LaneW'($urandom_range(15));
        2:       dims[k*LaneW +: LaneW] = ($urandom_range(7) == 0) ? 16'h0000 : 16'hffff;
        default: dims[k*LaneW +: LaneW] = LaneW'($urandom_range(4096));
      endcase
    end
    wait_drained();
    write_reg(obpc_pkg::REG_ROT_X, cols[0]);
    write_reg(obpc_pkg::REG_ROT_Y, cols[1]);
    write_reg(obpc_pkg::REG_ROT_Z, cols[2]);
    write_reg(obpc_pkg::REG_CENTER, ctr);
    write_reg(obpc_pkg::REG_DIMS, dims);
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                                          RegW'({$urandom, $urandom}));
    cfg_we_i <= 1'b0;
    box_loads++;
  endtask

  function automatic logic [LaneW-1:0] near_lane(int k);
    int span;
    int v;
    span = int'(box_cfg.dims[k*LaneW +: LaneW]);
    span = span / 2 + span / 8 + 3;
    v = int'(lane_signed(box_cfg.center, k)) + $urandom_range(2 * span) - span;
    return v[LaneW-1:0];
  endfunction

  task automatic send_random_point();
    logic [LaneW-1:0] p [3];
    logic             last;
    for (int k = 0; k < 3; k++)
      p[k] = ($urandom_range(9) < 6) ? near_lane(k) : LaneW'($urandom_range(65535));
    last = ($urandom_range(7) == 0);
    send_predicted(p[0], p[1], p[2], last);
  endtask

  initial begin
    int unsigned phase_idle [3];
    stim_row_t   r;
    phase_idle   = '{31, 48, 0};
    idle_pct     = phase_idle[0];
    box_cfg      = '{rot_x: obpc_pkg::ROT_X_RST, rot_y: obpc_pkg::ROT_Y_RST,
                     rot_z: obpc_pkg::ROT_Z_RST, center: '0, dims: '0};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    start_i      = 1'b0;
    point_x_i    = '0;
    point_y_i    = '0;
    point_z_i    = '0;
    last_point_i = 1'b0;

    // reset box: identity rotation, zero center, zero extents
    add_point(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1);
    add_point(16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0);
    add_point(16'h0000, 16'h0000, 16'hffff, 1'b0, 1'b1, 1'b0);
    add_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b1, 1'b0);
    add_point(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1, 1'b0);
    // full extents
    add_reg(obpc_pkg::REG_DIMS, 48'hffff_ffff_ffff);
    add_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b1, 1'b1);
    add_point(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0);
    add_point(16'h8001, 16'h0000, 16'h7fff, 1'b0, 1'b0, 1'b0);
    // extreme centers
    add_reg(obpc_pkg::REG_CENTER, 48'h7fff_7fff_7fff);
    add_point(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0);
    add_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b0, 1'b0);
    add_reg(obpc_pkg::REG_CENTER, 48'h8000_8000_8000);
    add_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b0, 1'b0);
    add_point(16'h8000, 16'h0000, 16'h8000, 1'b0, 1'b0, 1'b0);
    // extreme, non-orthonormal and all-zero rotation columns
    add_reg(obpc_pkg::REG_ROT_X, 48'h8000_8000_8000);
    add_reg(obpc_pkg::REG_ROT_Y, 48'h7fff_7fff_7fff);
    add_reg(obpc_pkg::REG_ROT_Z, 48'h0000_0000_0000);
    add_point(16'h7fff, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0);
    add_point(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, 1'b0);
    add_point(16'h1234, 16'hedcb, 16'h0f0f, 1'b0, 1'b0, 1'b0);
    // unused indexes must leave the box alone
    add_reg(REG_UNUSED_LO, 48'hffff_ffff_ffff);
    add_reg(REG_UNUSED_HI, 48'h0000_0000_0000);
    add_point(16'h7fff, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0);
    add_point(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
    // tiny box around the origin, points on and just off the surface
    add_reg(obpc_pkg::REG_ROT_X, obpc_pkg::ROT_X_RST);
    add_reg(obpc_pkg::REG_ROT_Y, obpc_pkg::ROT_Y_RST);
    add_reg(obpc_pkg::REG_ROT_Z, obpc_pkg::ROT_Z_RST);
    add_reg(obpc_pkg::REG_CENTER, 48'h0000_0000_0000);
    add_reg(obpc_pkg::REG_DIMS, 48'h0002_0002_0002);
    add_point(16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_point(16'h0002, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_point(16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0, 1'b0);
    add_point(16'h0000, 16'h0001, 16'hfffe, 1'b1, 1'b0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_REG) begin
        wait_drained();
        write_reg(r.idx, r.data);
        cfg_we_i <= 1'b0;
      end else if (r.has_keep) begin
        send_point(r.x, r.y, r.z, r.last, r.keep);
      end else begin
        send_predicted(r.x, r.y, r.z, r.last);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_idle[ph];
      for (int seg = 0; seg < 4; seg++) begin
        load_random_box();
        for (int n = 0; n < 84; n++) send_random_point();
      end
    end

    start_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("%0d points sent over %0d random boxes, %0d results checked, %0d kept",
             points_sent, box_loads, results_seen, points_kept);
    $display("%0d mismatches, %0d results still outstanding", mismatches,
             pending_points.size());
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("oriented_box_point_crop_core verification clean");
    end else begin
      $display("oriented_box_point_crop_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/obpc_pkg.sv
src/obpc_cfg.sv
src/obpc_proj.sv
src/obpc_cmp.sv
src/oriented_box_point_crop_core.sv
tb/sv/oriented_box_point_crop_core_tb.sv
